@@ rtl/lbpc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lbpc_pkg
// Shared types and constants for the LCG byte pattern checker.
// ----------------------------------------------------------------------------
package lbpc_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned OP_W     = 2;

    // LCG step: word * LCG_MULT + LCG_INC, modulo 2^32
    localparam logic [WORD_W-1:0] LCG_MULT   = 32'd1103515245;
    localparam logic [WORD_W-1:0] LCG_INC    = 32'd12345;
    localparam logic [WORD_W-1:0] SEED_RESET = 32'h1234_5678;
    localparam logic [WORD_W-1:0] OFFSET_MAX = 32'hFFFF_FFFF;

    // Register map (byte addresses 4*i)
    localparam int unsigned PADDR_W = 3;
    localparam logic [0:0]  REG_START_SEED = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_RESTART = 2'd0,
        OP_GEN     = 2'd1,
        OP_CHECK   = 2'd2
    } t_op;

endpackage : lbpc_pkg
`default_nettype wire

@@ rtl/lcg_byte_pattern_checker.sv @@
`default_nettype none
// A result passes through the input register and then the result register before it is
// valid on m_axis.
// Throughput: one item per cycle while m_axis is ready; the 32x32 LCG multiply in the
// compute stage sets the clock period, and the generator state feeds back there.
// Reset (synchronous, active low): generator word and start seed 0x12345678,
// byte offset 0, error marks cleared, both pipeline stages empty.
// ----------------------------------------------------------------------------
// lcg_byte_pattern_checker
// Byte pattern generator/checker driven by a 32-bit linear congruential
// generator, with an APB register for the restart seed.
// ----------------------------------------------------------------------------
module lcg_byte_pattern_checker
    import lbpc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    // APB configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_W-1:0]    paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,

    // Input stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,   // [7:0] data_byte
    input  wire logic [OP_W-1:0]       s_axis_tuser,   // [1:0] op
    input  wire logic                  s_axis_tlast,   // last_item

    // Result stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [47:0]                m_axis_tdata,   // [7:0] pattern_byte,
                                                       // [8] byte_mismatch,
                                                       // [9] error_seen,
                                                       // [41:10] first_error_offset,
                                                       // [47:42] zero
    output logic                       m_axis_tlast    // run_end
);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] r_start_seed;
    logic              w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;
    // Low address bits pick a byte lane within the word and are ignored.
    assign prdata   = (paddr[2] == REG_START_SEED) ? r_start_seed : 32'd0;

    // ------------------------------------------------------------------
    // Pipeline handshake
    //   Stage 1: input register holds one accepted transfer.
    //   Stage 2: compute against generator state, load result register.
    // Stage 1 refills whenever it is empty or moves on this cycle, so a
    // result stalled on m_axis still lets one more transfer in.
    // ------------------------------------------------------------------
    logic r_in_valid;
    logic r_out_valid;
    logic w_out_free;   // result register can take a new result
    logic w_fire;       // stage 1 item gets processed this cycle
    logic w_in_take;    // input transfer this cycle

    assign w_out_free    = ~r_out_valid | m_axis_tready;
    assign w_fire        = r_in_valid & w_out_free;
    assign s_axis_tready = ~r_in_valid | w_out_free;
    assign w_in_take     = s_axis_tvalid & s_axis_tready;

    // Stage 1 payload
    logic [OP_W-1:0]   r_op;
    logic [BYTE_W-1:0] r_data;
    logic              r_last;

    // ------------------------------------------------------------------
    // Generator and checker state
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] r_offset;
    logic              r_err;
    logic [WORD_W-1:0] r_first_bad;

    logic [WORD_W-1:0] n_word;
    logic [WORD_W-1:0] n_offset;
    logic              n_err;
    logic [WORD_W-1:0] n_first_bad;

    logic [WORD_W-1:0] w_word_adv;
    logic [WORD_W-1:0] w_word_cur;
    logic [BYTE_W-1:0] w_pat;
    logic [WORD_W-1:0] w_offset_inc;
    logic              w_miss;
    logic [BYTE_W-1:0] n_out_pat;
    logic              n_out_miss;

    // Word advances on every fourth offset, before the byte is taken.
    assign w_word_adv   = r_word * LCG_MULT + LCG_INC;
    assign w_word_cur   = (r_offset[1:0] == 2'd0) ? w_word_adv : r_word;
    // Offset saturates; the max value has lane 3, so the word then freezes.
    assign w_offset_inc = (r_offset == OFFSET_MAX) ? r_offset : r_offset + 32'd1;

    // LSB-first byte lane select
    always_comb begin
        case (r_offset[1:0])
            2'd0:    w_pat = w_word_cur[7:0];
            2'd1:    w_pat = w_word_cur[15:8];
            2'd2:    w_pat = w_word_cur[23:16];
            default: w_pat = w_word_cur[31:24];
        endcase
    end

    assign w_miss = (w_pat != r_data);

    always_comb begin
        n_word      = r_word;
        n_offset    = r_offset;
        n_err       = r_err;
        n_first_bad = r_first_bad;
        n_out_pat   = '0;
        n_out_miss  = 1'b0;
        unique case (r_op)
            OP_RESTART: begin
                n_word      = r_start_seed;
                n_offset    = '0;
                n_err       = 1'b0;
                n_first_bad = '0;
            end
            OP_GEN: begin
                n_word    = w_word_cur;
                n_offset  = w_offset_inc;
                n_out_pat = w_pat;
            end
            OP_CHECK: begin
                n_word     = w_word_cur;
                n_offset   = w_offset_inc;
                n_out_pat  = w_pat;
                n_out_miss = w_miss;
                // only the first miss since restart latches its offset
                if (w_miss && !r_err) begin
                    n_err       = 1'b1;
                    n_first_bad = r_offset;
                end
            end
            default: begin
                // unused code: no state change, zero pattern byte
            end
        endcase
    end

    // Result register payload
    logic [BYTE_W-1:0] r_out_pat;
    logic              r_out_miss;
    logic              r_out_err;
    logic [WORD_W-1:0] r_out_first;
    logic              r_out_last;

    // ------------------------------------------------------------------
    // Control and state registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_seed <= SEED_RESET;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_word       <= SEED_RESET;
            r_offset     <= '0;
            r_err        <= 1'b0;
            r_first_bad  <= '0;
        end else begin
            if (w_cfg_wr && paddr[2] == REG_START_SEED) begin
                r_start_seed <= pwdata;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (w_fire) begin
                r_word      <= n_word;
                r_offset    <= n_offset;
                r_err       <= n_err;
                r_first_bad <= n_first_bad;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_op   <= s_axis_tuser;
            r_data <= s_axis_tdata;
            r_last <= s_axis_tlast;
        end
        if (w_fire) begin
            r_out_pat   <= n_out_pat;
            r_out_miss  <= n_out_miss;
            r_out_err   <= n_err;
            r_out_first <= n_first_bad;
            r_out_last  <= r_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_first, r_out_err, r_out_miss, r_out_pat};
    assign m_axis_tlast  = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // error flag only clears on a restart
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err && !(w_fire && r_op == OP_RESTART)) |=> r_err)
        else $error("error flag dropped without restart");

    // no error means no latched offset
    a_first_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_err |-> (r_first_bad == '0))
        else $error("first error offset set without error flag");

    // a reported mismatch always comes with the sticky flag
    a_miss_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_miss) |-> r_out_err)
        else $error("mismatch reported without error flag");

    // restart reloads the seed and clears the offset
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_op == OP_RESTART) |=>
            (r_offset == '0 && r_word == $past(r_start_seed)))
        else $error("restart did not reload generator");

    // a held stage 1 item is neither lost nor overwritten
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_out_free) |=> (r_in_valid && $stable(r_op) && $stable(r_data)))
        else $error("stalled input item lost");

endmodule : lcg_byte_pattern_checker
`default_nettype wire
